// ===== hw/rtl/pdwm_pkg.sv =====
`default_nettype none
package pdwm_pkg;
    localparam int WinLen = 19;
    localparam int DataW = 16;
    localparam int ErrW = 18;
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] RegPropGain = 1'd0;
    localparam logic [CfgIdxW-1:0] RegDerivGain = 1'd1;
    localparam logic [15:0] PropGainRst = 16'd256;
    localparam logic [15:0] DerivGainRst = 16'd0;
    localparam logic [7:0] CorrMul = 8'd179;
    localparam logic [ErrW-1:0] CorrOffset = 18'd1024;
endpackage
`default_nettype wire

// ===== hw/rtl/pdwm_if.sv =====
`default_nettype none
interface pdwm_if #(parameter int W = 16) (input wire logic i_clk);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pdwm_front.sv =====
`default_nettype none
module pdwm_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_sensor,
    input  wire logic [15:0] i_target,
    input  wire logic [15:0] i_kp,
    input  wire logic [15:0] i_kd,
    output logic             o_q_valid,
    input  wire logic        i_q_ready,
    output logic signed [15:0] o_q_speed
);
    typedef enum logic [2:0] {S_IDLE, S_CORR, S_MUL, S_SUM, S_OUT} t_state;
    t_state r_state;
    logic signed [17:0] r_err, r_last_err, r_derr;
    logic signed [34:0] r_pe, r_de;
    logic signed [15:0] r_speed;
    logic [23:0] prod;
    logic signed [17:0] reading;
    logic signed [35:0] acc;
    logic signed [27:0] shr;

    assign prod = i_sensor * pdwm_pkg::CorrMul;
    assign reading = $signed({2'b00, prod[23:8]}) - $signed(pdwm_pkg::CorrOffset);
    assign acc = 36'(r_pe) + 36'(r_de);
    assign shr = acc[35:8];
    assign o_in_ready = (r_state == S_IDLE);
    assign o_q_valid = (r_state == S_OUT);
    assign o_q_speed = r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last_err <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_err <= $signed({2'b00, i_target}) - reading;
                    r_state <= S_CORR;
                end
                S_CORR: begin
                    r_derr <= r_err - r_last_err;
                    r_last_err <= r_err;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pe <= $signed({1'b0, i_kp}) * r_err;
                    r_de <= $signed({1'b0, i_kd}) * r_derr;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (shr > 28'sd32767) r_speed <= 16'sh7fff;
                    else if (shr < -28'sd32768) r_speed <= -16'sh8000;
                    else r_speed <= shr[15:0];
                    r_state <= S_OUT;
                end
                S_OUT: if (i_q_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pdwm_queue.sv =====
`default_nettype none
module pdwm_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_data
);
    logic [15:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pdwm_back.sv =====
`default_nettype none
module pdwm_back #(parameter int WIN = pdwm_pkg::WinLen) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_speed,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_median
);
    localparam int IW = $clog2(WIN);
    localparam int AW = $clog2(WIN);
    typedef enum logic [2:0] {S_IDLE, S_FIND, S_SORT, S_OUT} t_state;
    t_state r_state;
    logic signed [15:0] r_val [WIN];
    logic [AW-1:0] r_age [WIN];
    logic r_primed;
    logic [IW-1:0] r_pos;
    logic r_down, r_first;
    logic [15:0] r_med;
    logic signed [15:0] r_new;
    logic [IW-1:0] n_pos;
    logic found;

    always_comb begin
        n_pos = '0;
        found = 1'b0;
        for (int i = 0; i < WIN; i++) begin
            if (!found && r_age[i] == AW'(WIN-1)) begin
                n_pos = IW'(i);
                found = 1'b1;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_median = r_med;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_primed <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    if (!r_primed) begin
                        for (int i = 0; i < WIN; i++) begin
                            r_val[i] <= i_speed;
                            r_age[i] <= AW'(i);
                        end
                        r_primed <= 1'b1;
                        r_med <= i_speed;
                        r_state <= S_OUT;
                    end else begin
                        r_new <= i_speed;
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    for (int i = 0; i < WIN; i++)
                        if (IW'(i) != n_pos && r_age[i] < AW'(WIN-1))
                            r_age[i] <= r_age[i] + 1'b1;
                    r_age[n_pos] <= '0;
                    r_val[n_pos] <= r_new;
                    r_pos <= n_pos;
                    r_first <= 1'b1;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    r_first <= 1'b0;
                    if ((r_first || r_down) && r_pos != '0
                        && r_val[r_pos-1'b1] > r_val[r_pos]) begin
                        r_down <= 1'b1;
                        r_val[r_pos-1'b1] <= r_val[r_pos];
                        r_val[r_pos] <= r_val[r_pos-1'b1];
                        r_age[r_pos-1'b1] <= r_age[r_pos];
                        r_age[r_pos] <= r_age[r_pos-1'b1];
                        r_pos <= r_pos - 1'b1;
                    end else if (!(r_first ? 1'b0 : r_down) && r_pos != IW'(WIN-1)
                        && r_val[r_pos+1'b1] < r_val[r_pos]) begin
                        r_down <= 1'b0;
                        r_val[r_pos+1'b1] <= r_val[r_pos];
                        r_val[r_pos] <= r_val[r_pos+1'b1];
                        r_age[r_pos+1'b1] <= r_age[r_pos];
                        r_age[r_pos] <= r_age[r_pos+1'b1];
                        r_pos <= r_pos + 1'b1;
                    end else begin
                        r_med <= r_val[WIN/2];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pd_wall_distance_median_speed_top.sv =====
// the front computes the error, its difference, the gain products and the saturated
// sum in turn, a two-entry queue follows, and the back's insertion sort walks the window
// one adjacent swap per cycle; front and back each take a new item only when idle
// reset: synchronous active low, clears gains to defaults, last error and primed flag
`default_nettype none
module pd_wall_distance_median_speed_top #(parameter int WIN = pdwm_pkg::WinLen) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pdwm_if.sink      in_ch,
    pdwm_if.source    out_ch,
    input  wire logic i_cfg_we,
    input  wire logic [pdwm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    logic [15:0] r_kp, r_kd;
    logic fq_v, fq_r, qb_v, qb_r;
    logic [15:0] fq_d, qb_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= pdwm_pkg::PropGainRst;
            r_kd <= pdwm_pkg::DerivGainRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdwm_pkg::RegPropGain:  r_kp <= i_cfg_data;
                pdwm_pkg::RegDerivGain: r_kd <= i_cfg_data;
                default: ;
            endcase
        end
    end
    pdwm_front u_front (.i_clk, .i_rst_n, .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_sensor(in_ch.data[15:0]), .i_target(in_ch.data[31:16]), .i_kp(r_kp), .i_kd(r_kd),
        .o_q_valid(fq_v), .i_q_ready(fq_r), .o_q_speed(fq_d));
    pdwm_queue u_queue (.i_clk, .i_rst_n, .i_valid(fq_v), .o_ready(fq_r), .i_data(fq_d),
        .o_valid(qb_v), .i_ready(qb_r), .o_data(qb_d));
    pdwm_back #(.WIN(WIN)) u_back (.i_clk, .i_rst_n, .i_valid(qb_v), .o_ready(qb_r),
        .i_speed(qb_d), .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_median(out_ch.data));
endmodule
`default_nettype wire

// ===== hw/rtl/pdwm_checker.sv =====
`default_nettype none
module pdwm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_v, in_r, out_v, out_r,
    input wire logic [15:0] out_d
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_v && !out_r |=> out_v && $stable(out_d)) else $error("out hold");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_v) else $error("rst");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_v && in_r |=> !in_r) else $error("busy");
endmodule
bind pd_wall_distance_median_speed_top pdwm_checker u_chk (.i_clk, .i_rst_n,
    .in_v(in_ch.valid), .in_r(in_ch.ready), .out_v(out_ch.valid), .out_r(out_ch.ready),
    .out_d(out_ch.data[15:0]));
`default_nettype wire

// ===== test/pdwm_sb.sv =====
`timescale 1ns / 100ps
class pdwm_sb;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic signed [17:0] prev_err;
    logic signed [15:0] win_val [pdwm_pkg::WinLen];
    int win_age [pdwm_pkg::WinLen];
    bit primed;
    logic signed [15:0] median_q[$];
    int errors;

    function new();
        prop_gain = pdwm_pkg::PropGainRst;
        deriv_gain = pdwm_pkg::DerivGainRst;
        prev_err = '0;
        primed = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [pdwm_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
        if (idx == pdwm_pkg::RegPropGain) prop_gain = val;
        else if (idx == pdwm_pkg::RegDerivGain) deriv_gain = val;
    endfunction

    function void note_input(logic [15:0] sensor, logic [15:0] target);
        longint reading, err, derr, acc, speed;
        int pos, n;
        logic signed [15:0] tv;
        int ta;
        n = pdwm_pkg::WinLen;
        reading = ((longint'(sensor) * 179) >>> 8) - 1024;
        err = longint'(target) - reading;
        derr = err - longint'(prev_err);
        acc = longint'(prop_gain) * err + longint'(deriv_gain) * derr;
        speed = acc >>> 8;
        if (speed > 32767) speed = 32767;
        if (speed < -32768) speed = -32768;
        prev_err = err[17:0];
        if (!primed) begin
            for (int i = 0; i < n; i++) begin
                win_val[i] = speed[15:0];
                win_age[i] = i;
            end
            primed = 1;
        end else begin
            pos = -1;
            for (int i = 0; i < n; i++)
                if (pos < 0 && win_age[i] == n - 1) pos = i;
            if (pos < 0) pos = 0;
            for (int i = 0; i < n; i++)
                if (i != pos && win_age[i] < n - 1) win_age[i]++;
            win_val[pos] = speed[15:0];
            win_age[pos] = 0;
            if (pos > 0 && win_val[pos-1] > win_val[pos]) begin
                while (pos > 0 && win_val[pos-1] > win_val[pos]) begin
                    tv = win_val[pos-1]; win_val[pos-1] = win_val[pos]; win_val[pos] = tv;
                    ta = win_age[pos-1]; win_age[pos-1] = win_age[pos]; win_age[pos] = ta;
                    pos--;
                end
            end else begin
                while (pos < n - 1 && win_val[pos+1] < win_val[pos]) begin
                    tv = win_val[pos+1]; win_val[pos+1] = win_val[pos]; win_val[pos] = tv;
                    ta = win_age[pos+1]; win_age[pos+1] = win_age[pos]; win_age[pos] = ta;
                    pos++;
                end
            end
        end
        median_q.push_back(win_val[n/2]);
    endfunction

    function void report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endfunction

    function void check_median(logic [15:0] got);
        logic signed [15:0] want;
        if (median_q.size() == 0) begin
            report($sformatf("unexpected median %0d", $signed(got)));
            return;
        end
        want = median_q.pop_front();
        if (got !== want)
            report($sformatf("median got %0d want %0d", $signed(got), want));
    endfunction
endclass

// ===== test/pd_wall_distance_median_speed_top_test.sv =====
`timescale 1ns / 100ps
module pd_wall_distance_median_speed_top_test;
    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [pdwm_pkg::CfgIdxW-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;
    bit in_quiet;
    bit out_quiet;
    bit hold_off;
    bit sending_done;
    pdwm_sb sb;

    pdwm_if #(.W(32)) in_ch (i_clk);
    pdwm_if #(.W(16)) out_ch (i_clk);

    pd_wall_distance_median_speed_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("pd_wall_distance_median_speed_top test failed");
        $finish;
    end

    task automatic write_reg(logic [pdwm_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(logic [15:0] sensor, logic [15:0] target);
        while (!in_quiet && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {target, sensor};
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(sensor, target);
    endtask

    task automatic drain();
        while (sb.median_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_items(int cnt);
        logic [15:0] base;
        base = 16'($urandom);
        for (int k = 0; k < cnt; k++) begin
            case ($urandom_range(3))
                0: send(16'($urandom), 16'($urandom));
                1: send(16'(base + $urandom_range(1023)), base);
                2: send(16'($urandom_range(2047)), 16'($urandom_range(2047)));
                default: send({$urandom_range(1) ? 16'hffff : 16'h0}, 16'($urandom));
            endcase
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // output side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_off && (out_quiet || $urandom_range(99) >= 7);
            if (out_ch.valid && out_ch.ready)
                sb.check_median(out_ch.data);
        end
    end

    initial begin
        sb = new();
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 0;
        in_ch.data = '0;
        in_quiet = 0;
        out_quiet = 0;
        hold_off = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset gains, field extremes
        send(16'h0000, 16'h0000);
        send(16'hffff, 16'hffff);
        send(16'hffff, 16'h0000);
        send(16'h0000, 16'hffff);
        send(16'h8000, 16'h1234);
        send(16'h0005, 16'h0600);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        drain();
        // saturation both ways with large gains
        write_reg(pdwm_pkg::RegPropGain, 16'hffff);
        write_reg(pdwm_pkg::RegDerivGain, 16'hffff);
        send(16'h0000, 16'hffff);
        send(16'hffff, 16'h0000);
        send(16'h0000, 16'hffff);
        send(16'h7777, 16'h7777);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        drain();
        write_reg(pdwm_pkg::RegPropGain, 16'h0000);
        write_reg(pdwm_pkg::RegDerivGain, 16'h0000);
        random_items(40);
        drain();
        write_reg(pdwm_pkg::RegPropGain, 16'h0180);
        write_reg(pdwm_pkg::RegDerivGain, 16'h0040);
        random_items(400);
        drain();
        // long receiver stall while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            random_items(60);
        join
        drain();
        write_reg(pdwm_pkg::RegPropGain, 16'($urandom));
        write_reg(pdwm_pkg::RegDerivGain, 16'($urandom));
        in_quiet = 1;
        out_quiet = 1;
        random_items(300);
        in_quiet = 0;
        out_quiet = 0;
        drain();
        write_reg(pdwm_pkg::RegPropGain, 16'h0100);
        write_reg(pdwm_pkg::RegDerivGain, 16'hffff);
        random_items(400);
        drain();
        write_reg(pdwm_pkg::RegPropGain, 16'($urandom));
        write_reg(pdwm_pkg::RegDerivGain, 16'($urandom_range(255)));
        random_items(480);
        drain();

        if (sb.errors == 0)
            $display("pd_wall_distance_median_speed_top test passed");
        else
            $display("pd_wall_distance_median_speed_top test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/pdwm_pkg.sv
hw/rtl/pdwm_if.sv
hw/rtl/pdwm_front.sv
hw/rtl/pdwm_queue.sv
hw/rtl/pdwm_back.sv
hw/rtl/pd_wall_distance_median_speed_top.sv
hw/rtl/pdwm_checker.sv
test/pdwm_sb.sv
test/pd_wall_distance_median_speed_top_test.sv
